[src/aes_pkg.sv]
// Shared constants, types, S-box tables and field arithmetic for the AES-256 cipher.
package aes_pkg;

    localparam int NUM_ROUNDS_DEF = 14;
    localparam int KEY_REGS       = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 64;

    typedef struct packed {
        logic load;       // latch the input block; the sequencer latches kind in the same cycle
        logic exp_start;  // restart the round constant
        logic exp_step;   // produce one schedule word
        logic rnd_en;     // apply one round to the state
        logic rnd_first;  // initial key addition
        logic rnd_last;   // final round, no column mixing
        logic kind;       // 0 encrypt, 1 decrypt
    } aes_cmd_t;

    localparam logic [7:0] FWD_SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] col);
        logic [7:0] a [4];
        logic [7:0] r [4];
        for (int i = 0; i < 4; i++) a[i] = col[31 - 8 * i -: 8];
        for (int i = 0; i < 4; i++)
            r[i] = xtime(a[i]) ^ xtime(a[(i + 1) % 4]) ^ a[(i + 1) % 4]
                 ^ a[(i + 2) % 4] ^ a[(i + 3) % 4];
        mix_col = {r[0], r[1], r[2], r[3]};
    endfunction

    function automatic logic [31:0] inv_mix_col(input logic [31:0] col);
        logic [7:0] a  [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] r  [4];
        for (int i = 0; i < 4; i++)
        begin
            a[i]  = col[31 - 8 * i -: 8];
            x2[i] = xtime(a[i]);
            x4[i] = xtime(x2[i]);
            x8[i] = xtime(x4[i]);
        end
        for (int i = 0; i < 4; i++)
            r[i] = (x8[i] ^ x4[i] ^ x2[i])
                 ^ (x8[(i + 1) % 4] ^ x2[(i + 1) % 4] ^ a[(i + 1) % 4])
                 ^ (x8[(i + 2) % 4] ^ x4[(i + 2) % 4] ^ a[(i + 2) % 4])
                 ^ (x8[(i + 3) % 4] ^ a[(i + 3) % 4]);
        inv_mix_col = {r[0], r[1], r[2], r[3]};
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]],
                    FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
    endfunction

endpackage

[src/aes256_block_cipher.sv]
// Top level of the AES-256 block cipher: sequencer and datapath.
// A request runs the initial key addition and every round in turn; done is registered off the final round.
// Only one request is in flight: busy stays high from the accepting edge until the block is idle again.
// After any key write the next request first expands the schedule, then fetches its first round key.
// Reset clears the control state and zeroes the key registers; the schedule is rebuilt on use.
// Results are strobed for one cycle and the receiver cannot stall them.
module aes256_block_cipher #(
    parameter int NUM_ROUNDS = aes_pkg::NUM_ROUNDS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            kind,
    input  logic [63:0]                     block_high,
    input  logic [63:0]                     block_low,
    output logic                            done,
    output logic [63:0]                     out_high,
    output logic [63:0]                     out_low,
    input  logic                            cfg_we,
    input  logic [aes_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [aes_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // One row of the round-key store holds the four words of one round.
    localparam int ROW_W = $clog2(NUM_ROUNDS + 1);
    // The schedule counter walks every word of the expansion.
    localparam int EXP_W = $clog2(4 * (NUM_ROUNDS + 1));

    aes_pkg::aes_cmd_t cmd;
    logic [EXP_W-1:0]  exp_idx;
    logic [ROW_W-1:0]  rd_row;

    // The sequencer takes a request, expands the keys when reset or a key write has made them
    // stale, then steps through the initial key addition and every round.
    aes_ctrl #(
        .NUM_ROUNDS (NUM_ROUNDS),
        .ROW_W      (ROW_W),
        .EXP_W      (EXP_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .kind      (kind),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .busy      (busy),
        .done      (done),
        .cmd       (cmd),
        .exp_idx   (exp_idx),
        .rd_row    (rd_row)
    );

    // The datapath holds the state, which stays on the outputs after the last round
    // until the next request overwrites it.
    aes_datapath #(
        .NUM_ROUNDS (NUM_ROUNDS),
        .ROW_W      (ROW_W),
        .EXP_W      (EXP_W)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .block_high (block_high),
        .block_low  (block_low),
        .cmd        (cmd),
        .exp_idx    (exp_idx),
        .rd_row     (rd_row),
        .out_high   (out_high),
        .out_low    (out_low)
    );

endmodule

[src/aes_ctrl.sv]
// Sequencer for key expansion and the round loop of the AES-256 cipher.
module aes_ctrl #(
    parameter int NUM_ROUNDS = aes_pkg::NUM_ROUNDS_DEF,
    parameter int ROW_W      = $clog2(NUM_ROUNDS + 1),
    parameter int EXP_W      = $clog2(4 * (NUM_ROUNDS + 1))
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           kind,
    input  logic                           cfg_we,
    input  logic [aes_pkg::CFG_IDX_W-1:0]  cfg_index,
    output logic                           busy,
    output logic                           done,
    output aes_pkg::aes_cmd_t              cmd,
    output logic [EXP_W-1:0]               exp_idx,
    output logic [ROW_W-1:0]               rd_row
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EXPAND = 2'd1;
    localparam logic [1:0] ST_FETCH  = 2'd2;
    localparam logic [1:0] ST_ROUND  = 2'd3;

    localparam logic [EXP_W-1:0] EXP_LAST = EXP_W'(4 * (NUM_ROUNDS + 1) - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(NUM_ROUNDS);

    logic [1:0]       state_reg, state_next;
    logic [EXP_W-1:0] exp_idx_reg, exp_idx_next;
    logic [ROW_W-1:0] rnd_cnt_reg, rnd_cnt_next;
    logic             kind_reg, kind_next;
    logic             ready_reg, ready_next;
    logic             done_reg, done_next;
    logic             accept;

    assign accept  = (state_reg == ST_IDLE) && start;
    assign busy    = (state_reg != ST_IDLE);
    assign done    = done_reg;
    assign exp_idx = exp_idx_reg;

    always_comb
    begin
        state_next   = state_reg;
        exp_idx_next = exp_idx_reg;
        rnd_cnt_next = rnd_cnt_reg;
        kind_next    = kind_reg;
        ready_next   = ready_reg;
        done_next    = 1'b0;
        cmd          = '0;
        cmd.kind     = kind_reg;
        rd_row       = '0;
        if (cfg_we && (cfg_index < aes_pkg::CFG_IDX_W'(aes_pkg::KEY_REGS)))
            ready_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                rd_row   = kind ? ROW_LAST : '0;
                cmd.load = accept;
                if (accept)
                begin
                    kind_next    = kind;
                    rnd_cnt_next = '0;
                    exp_idx_next = '0;
                    if (ready_reg)
                        state_next = ST_ROUND;
                    else
                    begin
                        state_next    = ST_EXPAND;
                        cmd.exp_start = 1'b1;
                    end
                end
            end
            ST_EXPAND:
            begin
                cmd.exp_step = 1'b1;
                exp_idx_next = exp_idx_reg + 1'b1;
                if (exp_idx_reg == EXP_LAST)
                begin
                    state_next = ST_FETCH;
                    ready_next = 1'b1;
                end
            end
            ST_FETCH:
            begin
                rd_row     = kind_reg ? ROW_LAST : '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.rnd_en    = 1'b1;
                cmd.rnd_first = (rnd_cnt_reg == '0);
                cmd.rnd_last  = (rnd_cnt_reg == ROW_LAST);
                rnd_cnt_next  = rnd_cnt_reg + 1'b1;
                if (rnd_cnt_reg != ROW_LAST)
                    rd_row = kind_reg ? (ROW_LAST - rnd_cnt_reg - 1'b1)
                                      : (rnd_cnt_reg + 1'b1);
                if (rnd_cnt_reg == ROW_LAST)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            exp_idx_reg <= '0;
            rnd_cnt_reg <= '0;
            kind_reg    <= 1'b0;
            ready_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            exp_idx_reg <= exp_idx_next;
            rnd_cnt_reg <= rnd_cnt_next;
            kind_reg    <= kind_next;
            ready_reg   <= ready_next;
            done_reg    <= done_next;
        end
    end

endmodule

[src/aes_datapath.sv]
// Key registers, round-key store, key schedule and round logic of the AES-256 cipher.
module aes_datapath #(
    parameter int NUM_ROUNDS = aes_pkg::NUM_ROUNDS_DEF,
    parameter int ROW_W      = $clog2(NUM_ROUNDS + 1),
    parameter int EXP_W      = $clog2(4 * (NUM_ROUNDS + 1))
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [aes_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [aes_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [63:0]                     block_high,
    input  logic [63:0]                     block_low,
    input  aes_pkg::aes_cmd_t               cmd,
    input  logic [EXP_W-1:0]                exp_idx,
    input  logic [ROW_W-1:0]                rd_row,
    output logic [63:0]                     out_high,
    output logic [63:0]                     out_low
);

    localparam int ROWS = NUM_ROUNDS + 1;

    logic [63:0]  key_reg [aes_pkg::KEY_REGS];
    logic [127:0] rk_mem  [ROWS];
    logic [127:0] rk_reg;
    logic [31:0]  win_reg [8];
    logic [7:0]   rcon_reg;
    logic [127:0] blk_reg;
    logic [127:0] state_reg, state_next;

    logic [31:0]  key_word, temp_word, new_word;
    logic         from_key;

    // Key registers reset to the all-zero key.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < aes_pkg::KEY_REGS; i++) key_reg[i] <= '0;
        end
        else if (cfg_we && (cfg_index < aes_pkg::CFG_IDX_W'(aes_pkg::KEY_REGS)))
            key_reg[cfg_index[1:0]] <= cfg_data;
    end

    // Schedule: one word a cycle, the last eight words kept in a window.
    assign from_key = (exp_idx < EXP_W'(8));
    assign key_word = exp_idx[0] ? key_reg[exp_idx[2:1]][31:0]
                                 : key_reg[exp_idx[2:1]][63:32];

    always_comb
    begin
        if (exp_idx[2:0] == 3'd0)
            temp_word = aes_pkg::sub_word({win_reg[0][23:0], win_reg[0][31:24]})
                      ^ {rcon_reg, 24'h0};
        else if (exp_idx[2:0] == 3'd4)
            temp_word = aes_pkg::sub_word(win_reg[0]);
        else
            temp_word = win_reg[0];
        new_word = from_key ? key_word : (win_reg[7] ^ temp_word);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exp_start)
            rcon_reg <= 8'h01;
        else if (cmd.exp_step && !from_key && (exp_idx[2:0] == 3'd0))
            rcon_reg <= aes_pkg::xtime(rcon_reg);
        if (cmd.exp_step)
        begin
            win_reg[0] <= new_word;
            for (int i = 1; i < 8; i++) win_reg[i] <= win_reg[i - 1];
            if (exp_idx[1:0] == 2'd3)
                rk_mem[exp_idx[EXP_W-1:2]] <= {win_reg[2], win_reg[1], win_reg[0], new_word};
        end
        rk_reg <= rk_mem[rd_row];
    end

    // Round logic: state byte 4c+r holds row r of column c.
    always_comb
    begin
        logic [7:0]   b  [16];
        logic [7:0]   e  [16];
        logic [7:0]   d  [16];
        logic [127:0] enc, dec, mixed, unmixed;
        for (int i = 0; i < 16; i++) b[i] = state_reg[127 - 8 * i -: 8];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                e[4 * c + r] = aes_pkg::FWD_SBOX[b[4 * ((c + r) % 4) + r]];
                d[4 * c + r] = aes_pkg::INV_SBOX[b[4 * ((c + 4 - r) % 4) + r]];
            end
        for (int i = 0; i < 16; i++)
        begin
            enc[127 - 8 * i -: 8] = e[i];
            dec[127 - 8 * i -: 8] = d[i];
        end
        dec = dec ^ rk_reg;
        for (int c = 0; c < 4; c++)
        begin
            mixed[127 - 32 * c -: 32]   = aes_pkg::mix_col(enc[127 - 32 * c -: 32]);
            unmixed[127 - 32 * c -: 32] = aes_pkg::inv_mix_col(dec[127 - 32 * c -: 32]);
        end
        if (cmd.rnd_first)
            state_next = blk_reg ^ rk_reg;
        else if (cmd.kind)
            state_next = cmd.rnd_last ? dec : unmixed;
        else
            state_next = (cmd.rnd_last ? enc : mixed) ^ rk_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            blk_reg <= {block_high, block_low};
        if (cmd.rnd_en)
            state_reg <= state_next;
    end

    assign out_high = state_reg[127:64];
    assign out_low  = state_reg[63:0];

endmodule

[tb/sv/aes256_result_checker.sv]
// Checker for the AES-256 block cipher: tracks key writes, predicts each result and compares.
module aes256_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        kind,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    input  logic        done,
    input  logic [63:0] out_high,
    input  logic [63:0] out_low,
    input  logic        cfg_we,
    input  logic [aes_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [aes_pkg::CFG_DATA_W-1:0] cfg_data,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  ROUNDS       = aes_pkg::NUM_ROUNDS_DEF;
    localparam int  SCHED_LEN    = 4 * (ROUNDS + 1);
    localparam bit  KIND_DECRYPT = 1'b1;

    logic [63:0]  key_regs [4];
    logic [31:0]  sched [SCHED_LEN];
    bit           sched_stale;
    logic [7:0]   st [16];
    logic [127:0] expected_blocks [$];

    function automatic logic [7:0] gf_double(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                acc ^= a;
            a = gf_double(a);
        end
        return acc;
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {aes_pkg::FWD_SBOX[w[31:24]], aes_pkg::FWD_SBOX[w[23:16]],
                aes_pkg::FWD_SBOX[w[15:8]], aes_pkg::FWD_SBOX[w[7:0]]};
    endfunction

    function automatic void build_schedule();
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        for (int i = 0; i < 4; i++)
        begin
            sched[2 * i]     = key_regs[i][63:32];
            sched[2 * i + 1] = key_regs[i][31:0];
        end
        for (int i = 8; i < SCHED_LEN; i++)
        begin
            t = sched[i - 1];
            if (i % 8 == 0)
            begin
                t  = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = gf_double(rc);
            end
            else if (i % 8 == 4)
                t = sbox_word(t);
            sched[i] = sched[i - 8] ^ t;
        end
        sched_stale = 1'b0;
    endfunction

    function automatic void add_key(input int rnd);
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                st[4 * c + r] ^= sched[4 * rnd + c][31 - 8 * r -: 8];
    endfunction

    function automatic void sub_state(input bit inverse);
        for (int i = 0; i < 16; i++)
            st[i] = inverse ? aes_pkg::INV_SBOX[st[i]] : aes_pkg::FWD_SBOX[st[i]];
    endfunction

    // A shift of 1 rotates row r left by r places, a shift of 3 rotates it right.
    function automatic void shift_state(input int dir);
        logic [7:0] t [16];
        t = st;
        for (int r = 1; r < 4; r++)
            for (int c = 0; c < 4; c++)
                st[4 * c + r] = t[4 * ((c + dir * r) & 3) + r];
    endfunction

    function automatic void mix_state(input logic [7:0] m0, input logic [7:0] m1,
                                      input logic [7:0] m2, input logic [7:0] m3);
        logic [7:0] a [4];
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
                a[r] = st[4 * c + r];
            for (int r = 0; r < 4; r++)
                st[4 * c + r] = gf_mul(m0, a[r]) ^ gf_mul(m1, a[(r + 1) & 3])
                              ^ gf_mul(m2, a[(r + 2) & 3]) ^ gf_mul(m3, a[(r + 3) & 3]);
        end
    endfunction

    function automatic logic [127:0] cipher_block(input bit dir, input logic [63:0] hi,
                                                  input logic [63:0] lo);
        logic [127:0] blk;
        blk = {hi, lo};
        if (sched_stale)
            build_schedule();
        for (int i = 0; i < 16; i++)
            st[i] = blk[127 - 8 * i -: 8];
        if (dir != KIND_DECRYPT)
        begin
            add_key(0);
            for (int rnd = 1; rnd < ROUNDS; rnd++)
            begin
                sub_state(1'b0);
                shift_state(1);
                mix_state(8'h02, 8'h03, 8'h01, 8'h01);
                add_key(rnd);
            end
            sub_state(1'b0);
            shift_state(1);
            add_key(ROUNDS);
        end
        else
        begin
            add_key(ROUNDS);
            for (int rnd = ROUNDS - 1; rnd >= 1; rnd--)
            begin
                shift_state(3);
                sub_state(1'b1);
                add_key(rnd);
                mix_state(8'h0e, 8'h0b, 8'h0d, 8'h09);
            end
            shift_state(3);
            sub_state(1'b1);
            add_key(0);
        end
        for (int i = 0; i < 16; i++)
            blk[127 - 8 * i -: 8] = st[i];
        return blk;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [127:0] want;
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                key_regs[i] = '0;
            sched_stale = 1'b1;
            expected_blocks.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_blocks.size() == 0)
                begin
                    errors++;
                    $display("%0t: result %h_%h arrived with nothing expected",
                             $time, out_high, out_low);
                end
                else
                begin
                    want = expected_blocks.pop_front();
                    if (out_high !== want[127:64])
                    begin
                        errors++;
                        $display("%0t: out_high expected %h actual %h",
                                 $time, want[127:64], out_high);
                    end
                    if (out_low !== want[63:0])
                    begin
                        errors++;
                        $display("%0t: out_low expected %h actual %h",
                                 $time, want[63:0], out_low);
                    end
                end
            end
            if (cfg_we && cfg_index < 4)
            begin
                key_regs[cfg_index] = cfg_data;
                sched_stale = 1'b1;
            end
            if (start && !busy)
                expected_blocks.push_back(cipher_block(kind, block_high, block_low));
            pending = expected_blocks.size();
        end
    end
endmodule

[tb/sv/aes256_block_cipher_test.sv]
// Testbench top for the AES-256 block cipher: clock, reset, key writes, requests and verdict.
module aes256_block_cipher_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Register indexes of the four key words; indexes from 4 upwards select nothing.
    localparam logic [2:0] REG_KEY_0   = 3'd0;
    localparam logic [2:0] REG_KEY_1   = 3'd1;
    localparam logic [2:0] REG_KEY_2   = 3'd2;
    localparam logic [2:0] REG_KEY_3   = 3'd3;
    localparam logic [2:0] REG_UNUSED  = 3'd4;
    localparam logic [2:0] REG_UNUSED_5 = 3'd5;
    localparam logic [2:0] REG_UNUSED_6 = 3'd6;
    localparam logic [2:0] REG_LAST    = 3'd7;
    localparam bit         KIND_ENCRYPT = 1'b0;
    localparam bit         KIND_DECRYPT = 1'b1;
    localparam int         SETTLE_CYCLES = 24;
    localparam int         RANDOM_PHASES = 7;
    localparam int         PHASE_ITEMS   = 195;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        kind;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        done;
    logic [63:0] out_high;
    logic [63:0] out_low;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    int          errors;
    int          pending;

    aes256_block_cipher u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .block_high (block_high),
        .block_low  (block_low),
        .done       (done),
        .out_high   (out_high),
        .out_low    (out_low),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // The checker sits beside the block and sees exactly what the block sees.
    aes256_result_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .block_high (block_high),
        .block_low  (block_low),
        .done       (done),
        .out_high   (out_high),
        .out_low    (out_low),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .errors     (errors),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Issues one request and holds it until the block is no longer busy. A gap of zero
    // leaves start high, so that the next request follows without a dead cycle.
    task automatic send_request(input bit dir, input logic [63:0] hi, input logic [63:0] lo,
                                input int gap);
        start      <= 1'b1;
        kind       <= dir;
        block_high <= hi;
        block_low  <= lo;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Key registers are only touched once the block has drained: every expected result has
    // come back and a settling wait has passed. Writes in a row keep the enable high.
    task automatic write_key(input logic [63:0] k0, input logic [63:0] k1,
                             input logic [63:0] k2, input logic [63:0] k3);
        logic [63:0] words [4];
        logic [2:0]  idx [4];
        words = '{k0, k1, k2, k3};
        idx   = '{REG_KEY_0, REG_KEY_1, REG_KEY_2, REG_KEY_3};
        start <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= words[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // A random 64-bit value, now and then one of the two extremes.
    function automatic logic [63:0] random_word();
        unique case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial
    begin
        int gap;
        logic [63:0] k [4];
        start      <= 1'b0;
        kind       <= KIND_ENCRYPT;
        block_high <= '0;
        block_low  <= '0;
        cfg_we     <= 1'b0;
        cfg_index  <= REG_KEY_0;
        cfg_data   <= '0;
        rst_n      <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Requests before any key write run with the all-zero key after reset.
        send_request(KIND_ENCRYPT, '0, '0, 0);
        send_request(KIND_DECRYPT, '1, '1, 3);
        send_request(KIND_ENCRYPT, '1, '0, 0);

        // The standard AES-256 example key and plaintext, in both directions.
        write_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                  64'h1011121314151617, 64'h18191a1b1c1d1e1f);
        send_request(KIND_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff, 0);
        send_request(KIND_DECRYPT, 64'h8ea2b7ca516745bf, 64'heafc49904b496089, 0);
        send_request(KIND_DECRYPT, '0, '0, 1);
        send_request(KIND_ENCRYPT, 64'h8000000000000000, 64'h0000000000000001, 0);

        // Writes to indexes beyond the key words must leave the key alone.
        start <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_UNUSED;
        cfg_data  <= '1;
        @(posedge clk);
        cfg_index <= REG_LAST;
        cfg_data  <= 64'h5a5a5a5a5a5a5a5a;
        @(posedge clk);
        cfg_index <= REG_UNUSED_5;
        @(posedge clk);
        cfg_index <= REG_UNUSED_6;
        @(posedge clk);
        cfg_we <= 1'b0;
        send_request(KIND_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff, 0);
        send_request(KIND_DECRYPT, '1, '0, 0);

        // All-ones key at both ends of the block range.
        write_key('1, '1, '1, '1);
        send_request(KIND_ENCRYPT, '0, '0, 0);
        send_request(KIND_DECRYPT, '0, '0, 0);
        send_request(KIND_ENCRYPT, '1, '1, 0);
        send_request(KIND_DECRYPT, '1, '1, 2);

        // Random phases, each under a fresh key. The first two use the extreme keys, the
        // last runs with no idling at all so that requests follow back to back.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            for (int i = 0; i < 4; i++)
                k[i] = (p == 0) ? '0 : (p == 1) ? '1 : {$urandom, $urandom};
            write_key(k[0], k[1], k[2], k[3]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                gap = 0;
                if (p < RANDOM_PHASES - 1 && $urandom_range(0, 3) == 0)
                    gap = $urandom_range(1, 12);
                send_request(1'($urandom_range(0, 1)), random_word(), random_word(), gap);
            end
        end

        start <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Far beyond the slowest correct run, which needs well under a millisecond.
    initial
    begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
